[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[hdl/gu2x_pkg.sv]
// ----------------------------------------------------------------------------
// gu2x_pkg
// Shared types, geometry constants and coefficient tables for the upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package gu2x_pkg;

    // frame geometry
    localparam int WIDTH      = 32;
    localparam int HEIGHT     = 24;
    localparam int UPSCALE    = 2;
    localparam int FRAME_SIZE = WIDTH * HEIGHT;
    localparam int ADDR_W     = $clog2(FRAME_SIZE);
    localparam int LOG_W      = $clog2(WIDTH);
    localparam int LOG_OW     = $clog2(WIDTH * UPSCALE);

    // field widths
    localparam int PIX_W  = 16;
    localparam int PIDX_W = 10;
    localparam int OIDX_W = 12;
    localparam int RES_W  = 25;

    // source address: column bits plus row bits taken from the output index
    localparam int SRC_W  = OIDX_W - LOG_OW - 1 + LOG_W;
    localparam int SA_W   = 13;     // signed tap address before clamping
    localparam int OFS_W  = 8;      // signed neighbour offset

    // arithmetic
    localparam int NTAPS     = 9;
    localparam int TAP_W     = 4;
    localparam int WGT_W     = 16;
    localparam int PROD_W    = PIX_W + WGT_W + 1;
    localparam int ACC_W     = PROD_W + 4;
    localparam int RES_SHIFT = 7;

    // kernel codes
    localparam logic [1:0] KS_SIGMA_0P5 = 2'd0;
    localparam logic [1:0] KS_SIGMA_1P0 = 2'd1;
    localparam logic [1:0] KS_SIGMA_2P0 = 2'd2;

    // tap classes
    localparam logic [1:0] TC_CORNER = 2'd0;
    localparam logic [1:0] TC_EDGE   = 2'd1;
    localparam logic [1:0] TC_CENTER = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic [PIDX_W-1:0]        pixel_index;
        logic signed [PIX_W-1:0]  pixel_value;
        logic [OIDX_W-1:0]        output_index;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_W-1:0]  result_value;
        logic [OIDX_W-1:0]        result_index;
    } t_out_item;

    // neighbour offset for quadrant q, tap z
    function automatic logic signed [OFS_W-1:0] tap_offset(
        input logic [1:0]       q,
        input logic [TAP_W-1:0] z
    );
        logic signed [OFS_W-1:0] wm1;
        logic signed [OFS_W-1:0] w0;
        logic signed [OFS_W-1:0] wp1;
        logic signed [OFS_W-1:0] r;
        wm1 = OFS_W'(-WIDTH - 1);
        w0  = OFS_W'(-WIDTH);
        wp1 = OFS_W'(-WIDTH + 1);
        r   = '0;
        case (q)
            2'd0: begin
                case (z)
                    4'd0:          r = wm1;
                    4'd1, 4'd2:    r = w0;
                    4'd3, 4'd6:    r = -OFS_W'(1);
                    default:       r = '0;
                endcase
            end
            2'd1: begin
                case (z)
                    4'd0, 4'd1:       r = w0;
                    4'd2:             r = wp1;
                    4'd5, 4'd8:       r = OFS_W'(1);
                    default:          r = '0;
                endcase
            end
            2'd2: begin
                case (z)
                    4'd0, 4'd3:    r = -OFS_W'(1);
                    4'd6:          r = OFS_W'(WIDTH - 1);
                    4'd7, 4'd8:    r = OFS_W'(WIDTH);
                    default:       r = '0;
                endcase
            end
            default: begin
                case (z)
                    4'd2, 4'd5:       r = OFS_W'(1);
                    4'd6, 4'd7:       r = OFS_W'(WIDTH);
                    4'd8:             r = OFS_W'(WIDTH + 1);
                    default:          r = '0;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_class(input logic [TAP_W-1:0] z);
        logic [1:0] c;
        case (z)
            4'd0, 4'd2, 4'd6, 4'd8: c = TC_CORNER;
            4'd4:                   c = TC_CENTER;
            default:                c = TC_EDGE;
        endcase
        return c;
    endfunction

    // Q1.15 weights; the unused kernel code behaves as sigma 2.0
    function automatic logic [WGT_W-1:0] weight(
        input logic [1:0] ks,
        input logic [1:0] cls
    );
        logic [WGT_W-1:0] w;
        case (ks)
            KS_SIGMA_0P5: begin
                case (cls)
                    TC_CORNER: w = 16'd815;
                    TC_EDGE:   w = 16'd3538;
                    default:   w = 16'd15355;
                endcase
            end
            KS_SIGMA_1P0: begin
                case (cls)
                    TC_CORNER: w = 16'd2551;
                    TC_EDGE:   w = 16'd4041;
                    default:   w = 16'd6401;
                endcase
            end
            default: begin
                case (cls)
                    TC_CORNER: w = 16'd3344;
                    TC_EDGE:   w = 16'd3780;
                    default:   w = 16'd4272;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/gu2x_ram.sv]
// ----------------------------------------------------------------------------
// gu2x_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gu2x_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/gauss_upscale_2x.sv]
// ----------------------------------------------------------------------------
// gauss_upscale_2x
// 2x Gaussian upsampler over a stored 32-wide frame of signed 16-bit pixels.
// ----------------------------------------------------------------------------
// A load transfer (mode 0) writes one source pixel into the frame RAM;
// loads beyond the frame are dropped. A compute transfer (mode 1) names
// one pixel of the doubled output frame and returns one result: nine
// neighbour taps, each clamped to the linear frame range, are read from
// the single RAM read port one per cycle and pass through one shared
// 16x17 multiplier and accumulator. A compute holds the input side through
// the tap reads, the RAM read, the multiply and accumulate stages and the
// result load, plus any time spent waiting for the result register to
// drain. The result register sits between the sides, so a new transfer is
// taken while the previous result is still pending. A pixel must be loaded
// before any compute reads it. The user must write kernel_select through
// i_cfg_we/i_cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gauss_upscale_2x (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire gu2x_pkg::t_in_item   i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output gu2x_pkg::t_out_item       o_out_data,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_data
);

    import gu2x_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    // control
    t_state             r_state,     n_state;
    logic [TAP_W-1:0]   r_tap,       n_tap;
    logic               r_v1;        // RAM data for tap r_tap1 is valid
    logic               r_v2;        // r_prod is valid
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_kernel_sel;

    // payload
    logic [SRC_W-1:0]          r_src,  n_src;
    logic [1:0]                r_quad, n_quad;
    logic [OIDX_W-1:0]         r_oidx, n_oidx;
    logic [TAP_W-1:0]          r_tap1;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc,  n_acc;
    t_out_item                 r_out,  n_out;

    logic                      in_xfer;
    logic                      out_free;
    logic                      load_out;

    // RAM ports
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [PIX_W-1:0]          ram_rdata;

    // tap address and MAC operands
    logic signed [OFS_W-1:0]   tap_ofs;
    logic signed [SA_W-1:0]    tap_sa;
    logic [WGT_W-1:0]          tap_wgt;
    logic signed [PROD_W-1:0]  mul_full;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Frame store: loads write straight through on the transfer cycle.
    // ------------------------------------------------------------------
    assign ram_we    = in_xfer && !i_in_data.mode &&
                       (OIDX_W'(i_in_data.pixel_index) < OIDX_W'(FRAME_SIZE));
    assign ram_waddr = ADDR_W'(i_in_data.pixel_index);

    gu2x_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (FRAME_SIZE)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.pixel_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Tap address: source + neighbour offset, clamped to the frame. The
    // clamp is linear, so a horizontal edge wraps into the adjacent row.
    // ------------------------------------------------------------------
    always_comb begin
        tap_ofs = tap_offset(r_quad, r_tap);
        tap_sa  = SA_W'(r_src) + SA_W'(tap_ofs);
        if (tap_sa < 0) begin
            ram_raddr = '0;
        end else if (tap_sa >= SA_W'(FRAME_SIZE)) begin
            ram_raddr = ADDR_W'(FRAME_SIZE - 1);
        end else begin
            ram_raddr = tap_sa[ADDR_W-1:0];
        end
    end

    // shared multiplier; weight is non-negative, so zero-extend it
    assign tap_wgt  = weight(r_kernel_sel, tap_class(r_tap1));
    assign mul_full = $signed(ram_rdata) * $signed({1'b0, tap_wgt});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_tap    = r_tap;
        n_src    = r_src;
        n_quad   = r_quad;
        n_oidx   = r_oidx;
        n_acc    = r_v2 ? (r_acc + ACC_W'(r_prod)) : r_acc;
        n_out    = r_out;
        load_out = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_data.mode) begin
                    // output row/2 (row bits above bit LOG_OW), then column/2
                    n_src  = {i_in_data.output_index[OIDX_W-1:LOG_OW+1],
                              i_in_data.output_index[LOG_W:1]};
                    n_quad = {i_in_data.output_index[LOG_OW],
                              i_in_data.output_index[0]};
                    n_oidx = i_in_data.output_index;
                    n_tap  = '0;
                    n_acc  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_tap = r_tap + TAP_W'(1);
                if (r_tap == TAP_W'(NTAPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land, then for the result slot
                if (!r_v1 && !r_v2 && out_free) begin
                    load_out = 1'b1;
                    n_out.result_value = r_acc[RES_W+RES_SHIFT-1:RES_SHIFT];
                    n_out.result_index = r_oidx;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_out_ready) || load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tap        <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_kernel_sel <= KS_SIGMA_2P0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_v1        <= (r_state == ST_RUN);
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_kernel_sel <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_quad <= n_quad;
        r_oidx <= n_oidx;
        r_tap1 <= r_tap;
        r_prod <= mul_full;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_tap_range, i_clk, i_rst_n, r_tap > TAP_W'(NTAPS), "tap counter overran")
    `ASSERT_PROP(a_idle_empty, i_clk, i_rst_n, (r_state == ST_IDLE) |-> (!r_v1 && !r_v2), "MAC pipe busy while idle")
    `ASSERT_PROP(a_v1_src, i_clk, i_rst_n, r_v1 |-> $past(r_state == ST_RUN), "tap data without a read")
    `ASSERT_PROP(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_DRAIN), "result without a compute")

endmodule

`default_nettype wire
